// File: rtl/kct_pkg.sv
// shared constants and types for the keypad countdown timer
`timescale 1ns / 1ps

package kct_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int FRAC_W = $clog2(TICKS_PER_SECOND);
	localparam int SEC_W = 13;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] mode_t;
	typedef logic [3:0] digit_t;
	typedef logic [4:0] key_code_t;
	typedef logic [8:0] coord_t;

	localparam opcode_t OP_TICK = 2'd0;
	localparam opcode_t OP_PRESS = 2'd1;
	localparam opcode_t OP_RELEASE = 2'd2;

	localparam mode_t MODE_STOPPED = 2'd0;
	localparam mode_t MODE_COUNTING = 2'd1;
	localparam mode_t MODE_ALARM = 2'd2;

	localparam key_code_t KEY_START = 5'd0;
	localparam key_code_t KEY_ZERO = 5'd1;
	localparam key_code_t KEY_CLEAR = 5'd2;
	localparam key_code_t KEY_LAST = 5'd11;
	localparam key_code_t KEY_OUTSIDE = 5'h1E;
	localparam key_code_t KEY_NONE = 5'h1F;

	localparam coord_t GRID_X_LO = 9'd34;
	localparam coord_t GRID_X_HI = 9'd286;
	localparam coord_t GRID_Y_HI = 9'd320;
	localparam coord_t CELL_W = 9'd84;
	localparam coord_t CELL_H = 9'd80;
	localparam coord_t MENU_Y = 9'd330;

	localparam digit_t DIGIT_MAX = 4'd9;
	localparam digit_t TENS_MAX = 4'd5;
	localparam digit_t TENS_LIMIT = 4'd6;

	typedef struct packed {
		logic in_grid;
		key_code_t code;
	} key_info_t;

endpackage

// File: rtl/kct_item_if.sv
// input channel: tick, press or release beats
`timescale 1ns / 1ps

interface kct_item_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [8:0] x_pos;
	logic [8:0] y_pos;

	modport source (output valid, opcode, x_pos, y_pos, input ready);
	modport sink (input valid, opcode, x_pos, y_pos, output ready);
endinterface

// File: rtl/kct_result_if.sv
// output channel: display digits and status per beat
`timescale 1ns / 1ps

interface kct_result_if;
	logic valid;
	logic ready;
	logic [3:0] minutes_tens;
	logic [3:0] minutes_ones;
	logic [3:0] seconds_tens;
	logic [3:0] seconds_ones;
	logic [1:0] mode;
	logic buzzer_on;
	logic refresh;
	logic to_menu;

	modport source (output valid, minutes_tens, minutes_ones, seconds_tens, seconds_ones,
		mode, buzzer_on, refresh, to_menu, input ready);
	modport sink (input valid, minutes_tens, minutes_ones, seconds_tens, seconds_ones,
		mode, buzzer_on, refresh, to_menu, output ready);
endinterface

// File: rtl/kct_keymap.sv
// touch coordinates to key code of the 3 x 4 keypad grid
`timescale 1ns / 1ps

module kct_keymap (
	input kct_pkg::coord_t x_pos,
	input kct_pkg::coord_t y_pos,
	output kct_pkg::key_info_t key
);
	logic [1:0] col;
	logic [1:0] row;
	logic [3:0] idx;

	always_comb begin
		if (x_pos < kct_pkg::GRID_X_LO + kct_pkg::CELL_W) begin
			col = 2'd0;
		end else if (x_pos < kct_pkg::GRID_X_LO + 9'(2 * kct_pkg::CELL_W)) begin
			col = 2'd1;
		end else begin
			col = 2'd2;
		end

		if (y_pos < kct_pkg::CELL_H) begin
			row = 2'd0;
		end else if (y_pos < 9'(2 * kct_pkg::CELL_H)) begin
			row = 2'd1;
		end else if (y_pos < 9'(3 * kct_pkg::CELL_H)) begin
			row = 2'd2;
		end else begin
			row = 2'd3;
		end

		idx = 4'({2'b00, row} * 4'd3) + {2'b00, col};
		key.in_grid = (x_pos > kct_pkg::GRID_X_LO) && (x_pos < kct_pkg::GRID_X_HI)
			&& (y_pos < kct_pkg::GRID_Y_HI);
		key.code = key.in_grid ? {1'b0, idx} : kct_pkg::KEY_OUTSIDE;
	end
endmodule

// File: rtl/keypad_countdown_timer_core.sv
// keypad countdown timer: input stage, timer state update and result register
//
// channel  dir  payload
// item     in   opcode, x_pos, y_pos
// result   out  minutes_tens, minutes_ones, seconds_tens, seconds_ones, mode,
//               buzzer_on, refresh, to_menu
//
// one beat per cycle unless result stalls; result valid rises as a beat enters its register
// the state update is one pass of shallow logic between the input stage and result register
// the countdown is kept as whole seconds plus a tick fraction, so no divider is needed
// arst_n clears mode, digits, counters, held key and both valid flags
// a stalled result holds the input stage, which then holds item.ready low
`timescale 1ns / 1ps

module keypad_countdown_timer_core (
	input logic clk,
	input logic arst_n,
	kct_item_if.sink item,
	kct_result_if.source result
);
	logic valid_s1;
	kct_pkg::opcode_t opcode_s1;
	kct_pkg::coord_t x_s1;
	kct_pkg::coord_t y_s1;

	kct_pkg::mode_t mode_q;
	kct_pkg::digit_t digit_q [4];
	logic [kct_pkg::SEC_W-1:0] sec_q;
	logic [kct_pkg::FRAC_W-1:0] frac_q;
	kct_pkg::key_code_t held_q;

	kct_pkg::mode_t mode_n;
	kct_pkg::digit_t digit_n [4];
	logic [kct_pkg::SEC_W-1:0] sec_n;
	logic [kct_pkg::FRAC_W-1:0] frac_n;
	kct_pkg::key_code_t held_n;
	logic refresh_n;
	logic to_menu_n;

	logic res_valid_q;
	kct_pkg::digit_t res_digit_q [4];
	kct_pkg::mode_t res_mode_q;
	logic res_refresh_q;
	logic res_to_menu_q;

	kct_pkg::key_info_t key;
	kct_pkg::digit_t dec_digit [4];
	kct_pkg::digit_t norm_digit [4];
	logic [6:0] key_min;
	logic [6:0] key_sec;
	logic [kct_pkg::SEC_W-1:0] key_total;
	logic fire;

	assign fire = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1 <= item.opcode;
			x_s1 <= item.x_pos;
			y_s1 <= item.y_pos;
		end
	end

	kct_keymap u_keymap (
		.x_pos(x_s1),
		.y_pos(y_s1),
		.key(key)
	);

	// one second off the shown digits, minutes wrap from 00 to 99
	always_comb begin
		dec_digit = digit_q;
		if (digit_q[3] != '0) begin
			dec_digit[3] = digit_q[3] - 4'd1;
		end else begin
			dec_digit[3] = kct_pkg::DIGIT_MAX;
			if (digit_q[2] != '0) begin
				dec_digit[2] = digit_q[2] - 4'd1;
			end else begin
				dec_digit[2] = kct_pkg::TENS_MAX;
				if (digit_q[1] != '0) begin
					dec_digit[1] = digit_q[1] - 4'd1;
				end else begin
					dec_digit[1] = kct_pkg::DIGIT_MAX;
					dec_digit[0] = (digit_q[0] != '0) ? digit_q[0] - 4'd1 : kct_pkg::DIGIT_MAX;
				end
			end
		end
	end

	// keyed MM:SS to total seconds and normal form
	always_comb begin
		key_min = 7'(7'(digit_q[0]) * 7'd10) + 7'(digit_q[1]);
		key_sec = 7'(7'(digit_q[2]) * 7'd10) + 7'(digit_q[3]);
		key_total = kct_pkg::SEC_W'(kct_pkg::SEC_W'(key_min) * kct_pkg::SEC_W'(60))
			+ kct_pkg::SEC_W'(key_sec);
		norm_digit = digit_q;
		if (digit_q[2] >= kct_pkg::TENS_LIMIT) begin
			norm_digit[2] = digit_q[2] - kct_pkg::TENS_LIMIT;
			if (digit_q[1] == kct_pkg::DIGIT_MAX) begin
				norm_digit[1] = '0;
				norm_digit[0] = (digit_q[0] == kct_pkg::DIGIT_MAX) ? '0 : digit_q[0] + 4'd1;
			end else begin
				norm_digit[1] = digit_q[1] + 4'd1;
			end
		end
	end

	always_comb begin
		mode_n = mode_q;
		digit_n = digit_q;
		sec_n = sec_q;
		frac_n = frac_q;
		held_n = held_q;
		refresh_n = 1'b0;
		to_menu_n = 1'b0;
		case (opcode_s1)
			kct_pkg::OP_TICK: begin
				if (mode_q == kct_pkg::MODE_COUNTING) begin
					if (frac_q == '0) begin
						frac_n = kct_pkg::FRAC_W'(kct_pkg::TICKS_PER_SECOND - 1);
						sec_n = sec_q - kct_pkg::SEC_W'(1);
						digit_n = dec_digit;
						refresh_n = 1'b1;
					end else begin
						frac_n = frac_q - kct_pkg::FRAC_W'(1);
						if (sec_q == '0 && frac_q == kct_pkg::FRAC_W'(1)) begin
							mode_n = kct_pkg::MODE_ALARM;
							refresh_n = 1'b1;
						end
					end
				end
			end
			kct_pkg::OP_PRESS: begin
				if (mode_q == kct_pkg::MODE_ALARM) begin
					mode_n = kct_pkg::MODE_STOPPED;
					refresh_n = 1'b1;
				end else if (key.code != held_q) begin
					held_n = key.code;
					refresh_n = 1'b1;
					if (key.code == kct_pkg::KEY_CLEAR) begin
						digit_n = '{default: '0};
						mode_n = kct_pkg::MODE_STOPPED;
					end else if (mode_q == kct_pkg::MODE_STOPPED && key.in_grid) begin
						if (key.code == kct_pkg::KEY_START) begin
							digit_n = norm_digit;
							sec_n = key_total;
							frac_n = '0;
							if (key_total != '0) begin
								mode_n = kct_pkg::MODE_COUNTING;
							end
						end else begin
							digit_n[0] = digit_q[1];
							digit_n[1] = digit_q[2];
							digit_n[2] = digit_q[3];
							digit_n[3] = (key.code == kct_pkg::KEY_ZERO) ? '0
								: 4'(key.code - kct_pkg::KEY_CLEAR);
						end
					end
				end
			end
			kct_pkg::OP_RELEASE: begin
				to_menu_n = (y_s1 > kct_pkg::MENU_Y) && (mode_q == kct_pkg::MODE_STOPPED);
				held_n = kct_pkg::KEY_NONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kct_pkg::MODE_STOPPED;
			digit_q <= '{default: '0};
			sec_q <= '0;
			frac_q <= '0;
			held_q <= kct_pkg::KEY_NONE;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				mode_q <= mode_n;
				digit_q <= digit_n;
				sec_q <= sec_n;
				frac_q <= frac_n;
				held_q <= held_n;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_digit_q <= digit_n;
			res_mode_q <= mode_n;
			res_refresh_q <= refresh_n;
			res_to_menu_q <= to_menu_n;
		end
	end

	assign result.valid = res_valid_q;
	assign result.minutes_tens = res_digit_q[0];
	assign result.minutes_ones = res_digit_q[1];
	assign result.seconds_tens = res_digit_q[2];
	assign result.seconds_ones = res_digit_q[3];
	assign result.mode = res_mode_q;
	assign result.buzzer_on = (res_mode_q == kct_pkg::MODE_ALARM);
	assign result.refresh = res_refresh_q;
	assign result.to_menu = res_to_menu_q;
endmodule

// File: rtl/kct_checker.sv
// port-level checks on the timer core and their bind
`timescale 1ns / 1ps

module kct_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input logic [3:0] minutes_tens,
	input logic [3:0] minutes_ones,
	input logic [3:0] seconds_tens,
	input logic [3:0] seconds_ones,
	input logic [1:0] mode,
	input logic buzzer_on,
	input logic refresh,
	input logic to_menu
);
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(mode)
			&& $stable(seconds_ones) && $stable(refresh))
		else $error("stalled result beat changed");

	a_buzzer_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> buzzer_on == (mode == kct_pkg::MODE_ALARM))
		else $error("buzzer does not follow alarm mode");

	a_menu_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && to_menu |-> mode == kct_pkg::MODE_STOPPED && !refresh)
		else $error("menu request outside stopped mode or with redraw");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> minutes_tens <= kct_pkg::DIGIT_MAX
			&& minutes_ones <= kct_pkg::DIGIT_MAX && seconds_tens <= kct_pkg::DIGIT_MAX
			&& seconds_ones <= kct_pkg::DIGIT_MAX)
		else $error("digit out of decimal range");

	a_counting_seconds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mode == kct_pkg::MODE_COUNTING |-> seconds_tens <= kct_pkg::TENS_MAX)
		else $error("seconds tens not normalized while counting");
endmodule

bind keypad_countdown_timer_core kct_checker u_kct_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.minutes_tens(result.minutes_tens),
	.minutes_ones(result.minutes_ones),
	.seconds_tens(result.seconds_tens),
	.seconds_ones(result.seconds_ones),
	.mode(result.mode),
	.buzzer_on(result.buzzer_on),
	.refresh(result.refresh),
	.to_menu(result.to_menu)
);

// File: tb/sv/keypad_countdown_timer_core_test.sv
// testbench for the keypad countdown timer core: directed and random beats checked against a predictor
`timescale 1ns / 1ps

typedef struct packed {
	kct_pkg::digit_t minutes_tens;
	kct_pkg::digit_t minutes_ones;
	kct_pkg::digit_t seconds_tens;
	kct_pkg::digit_t seconds_ones;
	kct_pkg::mode_t mode;
	logic buzzer_on;
	logic refresh;
	logic to_menu;
} display_view_t;

class countdown_scoreboard;
	localparam int HELD_NONE = -1;
	localparam int HELD_OUTSIDE = -2;
	localparam int KEYS_PER_ROW = 3;
	localparam int PRINT_CAP = 40;

	kct_pkg::mode_t run_mode;
	kct_pkg::digit_t digits[4];
	int unsigned ticks_left;
	int held_key;
	display_view_t expected_views[$];
	int mismatches;
	int beats_checked;
	int alarms_raised;
	int redraws;
	int menu_exits;

	function new();
		run_mode = kct_pkg::MODE_STOPPED;
		foreach (digits[i]) digits[i] = '0;
		ticks_left = 0;
		held_key = HELD_NONE;
		mismatches = 0;
		beats_checked = 0;
		alarms_raised = 0;
		redraws = 0;
		menu_exits = 0;
	endfunction

	// split a second count into mm:ss digits, minutes wrap at 100
	function void load_seconds(int unsigned secs);
		int unsigned mins;
		mins = secs / 10;
		digits[3] = kct_pkg::digit_t'(secs % 10);
		digits[2] = kct_pkg::digit_t'(mins % 6);
		mins = mins / 6;
		digits[1] = kct_pkg::digit_t'(mins % 10);
		digits[0] = kct_pkg::digit_t'((mins / 10) % 10);
	endfunction

	function void predict_beat(kct_pkg::opcode_t op, kct_pkg::coord_t x, kct_pkg::coord_t y);
		display_view_t view;
		int key;
		int unsigned secs;
		bit redraw;
		bit menu;
		redraw = 1'b0;
		menu = 1'b0;
		case (op)
			kct_pkg::OP_TICK: begin
				if (run_mode == kct_pkg::MODE_COUNTING) begin
					ticks_left--;
					if (ticks_left == 0) begin
						run_mode = kct_pkg::MODE_ALARM;
						redraw = 1'b1;
						alarms_raised++;
					end else if (ticks_left % kct_pkg::TICKS_PER_SECOND
						== kct_pkg::TICKS_PER_SECOND - 1) begin
						load_seconds(ticks_left / kct_pkg::TICKS_PER_SECOND);
						redraw = 1'b1;
					end
				end
			end
			kct_pkg::OP_PRESS: begin
				if (run_mode == kct_pkg::MODE_ALARM) begin
					run_mode = kct_pkg::MODE_STOPPED;
					redraw = 1'b1;
				end else begin
					if (x > kct_pkg::GRID_X_LO && x < kct_pkg::GRID_X_HI
						&& y < kct_pkg::GRID_Y_HI)
						key = int'(y / kct_pkg::CELL_H) * KEYS_PER_ROW
							+ int'((x - kct_pkg::GRID_X_LO) / kct_pkg::CELL_W);
					else
						key = HELD_OUTSIDE;
					if (key != held_key) begin
						held_key = key;
						redraw = 1'b1;
						if (key == int'(kct_pkg::KEY_CLEAR)) begin
							load_seconds(0);
							run_mode = kct_pkg::MODE_STOPPED;
						end else if (run_mode == kct_pkg::MODE_STOPPED
							&& key == int'(kct_pkg::KEY_START)) begin
							secs = (int'(digits[0]) * 10 + int'(digits[1])) * 60
								+ int'(digits[2]) * 10 + int'(digits[3]);
							if (secs != 0)
								run_mode = kct_pkg::MODE_COUNTING;
							load_seconds(secs);
							ticks_left = secs * kct_pkg::TICKS_PER_SECOND;
						end else if (run_mode == kct_pkg::MODE_STOPPED && key >= 0) begin
							digits[0] = digits[1];
							digits[1] = digits[2];
							digits[2] = digits[3];
							digits[3] = (key == int'(kct_pkg::KEY_ZERO)) ? kct_pkg::digit_t'(0)
								: kct_pkg::digit_t'(key - 2);
						end
					end
				end
			end
			kct_pkg::OP_RELEASE: begin
				if (y > kct_pkg::MENU_Y && run_mode == kct_pkg::MODE_STOPPED)
					menu = 1'b1;
				held_key = HELD_NONE;
			end
			default: begin
			end
		endcase
		view.minutes_tens = digits[0];
		view.minutes_ones = digits[1];
		view.seconds_tens = digits[2];
		view.seconds_ones = digits[3];
		view.mode = run_mode;
		view.buzzer_on = (run_mode == kct_pkg::MODE_ALARM);
		view.refresh = redraw;
		view.to_menu = menu;
		redraws += redraw;
		menu_exits += menu;
		expected_views.push_back(view);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch on %s at result beat %0d: got %0d, want %0d", what, beats_checked,
				got, want);
	endtask

	task check_result(display_view_t got);
		display_view_t want;
		beats_checked++;
		if (expected_views.size() == 0) begin
			report("result beat with nothing outstanding", 0, 0);
			return;
		end
		want = expected_views.pop_front();
		if (got.minutes_tens !== want.minutes_tens)
			report("minutes_tens", got.minutes_tens, want.minutes_tens);
		if (got.minutes_ones !== want.minutes_ones)
			report("minutes_ones", got.minutes_ones, want.minutes_ones);
		if (got.seconds_tens !== want.seconds_tens)
			report("seconds_tens", got.seconds_tens, want.seconds_tens);
		if (got.seconds_ones !== want.seconds_ones)
			report("seconds_ones", got.seconds_ones, want.seconds_ones);
		if (got.mode !== want.mode)
			report("mode", got.mode, want.mode);
		if (got.buzzer_on !== want.buzzer_on)
			report("buzzer_on", got.buzzer_on, want.buzzer_on);
		if (got.refresh !== want.refresh)
			report("refresh", got.refresh, want.refresh);
		if (got.to_menu !== want.to_menu)
			report("to_menu", got.to_menu, want.to_menu);
	endtask
endclass

module keypad_countdown_timer_core_test;
	localparam int IDLE_PCT = 18;
	localparam int RANDOM_BEATS = 1400;
	localparam int MIN_ALARM_RUNS = 1;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int KEY_DIGIT_ONE = 3;
	localparam kct_pkg::opcode_t OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	bit calm;
	int beats_sent;
	int alarm_runs;
	int quiet_cycles;
	countdown_scoreboard timer_sb;

	kct_item_if item_ch();
	kct_result_if result_ch();

	keypad_countdown_timer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send(kct_pkg::opcode_t op, kct_pkg::coord_t x, kct_pkg::coord_t y);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.x_pos <= x;
		item_ch.y_pos <= y;
		do @(posedge clk); while (!item_ch.ready);
		beats_sent++;
	endtask

	task automatic tick();
		send(kct_pkg::OP_TICK, kct_pkg::coord_t'($urandom_range(0, 511)),
			kct_pkg::coord_t'($urandom_range(0, 511)));
	endtask

	task automatic release_touch();
		send(kct_pkg::OP_RELEASE, kct_pkg::coord_t'($urandom_range(0, 511)),
			kct_pkg::coord_t'($urandom_range(0, 511)));
	endtask

	task automatic press_key(int k);
		int col;
		int row;
		col = k % 3;
		row = k / 3;
		send(kct_pkg::OP_PRESS,
			kct_pkg::coord_t'(kct_pkg::GRID_X_LO + col * kct_pkg::CELL_W
				+ $urandom_range(col == 0 ? 1 : 0, kct_pkg::CELL_W - 1)),
			kct_pkg::coord_t'(row * kct_pkg::CELL_H + $urandom_range(0, kct_pkg::CELL_H - 1)));
	endtask

	task automatic tap(int k);
		press_key(k);
		release_touch();
	endtask

	function automatic int random_digit_key();
		int k;
		k = $urandom_range(1, 10);
		return (k == 1) ? k : k + 1;
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (timer_sb.expected_views.size() != 0)
			@(posedge clk);
	endtask

	// one second on the clock, counted out to the alarm, then silenced
	task automatic run_to_alarm();
		release_touch();
		tap(kct_pkg::KEY_CLEAR);
		tap(KEY_DIGIT_ONE);
		tap(kct_pkg::KEY_START);
		repeat (kct_pkg::TICKS_PER_SECOND + $urandom_range(0, 4))
			tick();
		send(kct_pkg::OP_PRESS, kct_pkg::coord_t'($urandom_range(0, 511)),
			kct_pkg::coord_t'($urandom_range(0, 511)));
		release_touch();
		alarm_runs++;
	endtask

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				timer_sb.predict_beat(item_ch.opcode, item_ch.x_pos, item_ch.y_pos);
			if (result_ch.valid && result_ch.ready)
				timer_sb.check_result('{result_ch.minutes_tens, result_ch.minutes_ones,
					result_ch.seconds_tens, result_ch.seconds_ones, result_ch.mode,
					result_ch.buzzer_on, result_ch.refresh, result_ch.to_menu});
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("no beat moved for %0d cycles", QUIET_LIMIT);
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		int roll;
		int k;
		bit paused;
		timer_sb = new();
		arst_n = 1'b0;
		calm = 1'b0;
		paused = 1'b0;
		beats_sent = 0;
		alarm_runs = 0;
		quiet_cycles = 0;
		item_ch.valid = 1'b0;
		item_ch.opcode = kct_pkg::OP_TICK;
		item_ch.x_pos = '0;
		item_ch.y_pos = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: unused opcode, idle tick, menu edge, grid edges, 99:99 start, clear in count
		send(OP_UNUSED, 9'd511, 9'd511);
		send(kct_pkg::OP_TICK, 9'd511, 9'd511);
		send(kct_pkg::OP_RELEASE, 9'd0, 9'd331);
		send(kct_pkg::OP_RELEASE, 9'd511, 9'd330);
		send(kct_pkg::OP_PRESS, 9'd34, 9'd0);
		send(kct_pkg::OP_PRESS, 9'd100, 9'd320);
		send(kct_pkg::OP_PRESS, 9'd286, 9'd0);
		send(kct_pkg::OP_PRESS, 9'd35, 9'd0);
		send(kct_pkg::OP_RELEASE, 9'd0, 9'd0);
		repeat (4) begin
			send(kct_pkg::OP_PRESS, 9'd285, 9'd319);
			send(kct_pkg::OP_RELEASE, 9'd511, 9'd0);
		end
		send(kct_pkg::OP_PRESS, 9'd117, 9'd79);
		send(kct_pkg::OP_TICK, 9'd0, 9'd0);
		send(kct_pkg::OP_PRESS, 9'd202, 9'd0);
		send(kct_pkg::OP_TICK, 9'd0, 9'd0);
		send(kct_pkg::OP_PRESS, 9'd118, 9'd0);
		send(kct_pkg::OP_RELEASE, 9'd0, 9'd511);
		wait_drained();

		while (beats_sent < RANDOM_BEATS) begin
			calm = beats_sent > 200 && beats_sent < 400;
			if (!paused && beats_sent > 420) begin
				wait_drained();
				paused = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (alarm_runs < MIN_ALARM_RUNS && beats_sent > 450) begin
				run_to_alarm();
			end else if (roll < 32) begin
				if ($urandom_range(0, 1))
					tap(kct_pkg::KEY_CLEAR);
				repeat ($urandom_range(1, 5))
					tap(random_digit_key());
				tap(kct_pkg::KEY_START);
				repeat ($urandom_range(1, 40))
					tick();
			end else if (roll < 52) begin
				repeat ($urandom_range(1, 60)) begin
					k = $urandom_range(0, 14);
					if (k == 0)
						press_key($urandom_range(0, 11));
					else if (k == 1)
						release_touch();
					else
						tick();
				end
			end else if (roll < 67) begin
				k = $urandom_range(0, 11);
				press_key(k);
				press_key(k);
				if ($urandom_range(0, 1))
					press_key($urandom_range(0, 11));
				release_touch();
			end else if (roll < 77) begin
				press_key(kct_pkg::KEY_CLEAR);
				repeat ($urandom_range(1, 10))
					tick();
				release_touch();
			end else begin
				repeat ($urandom_range(1, 8))
					send(kct_pkg::opcode_t'($urandom_range(0, 3)),
						kct_pkg::coord_t'($urandom_range(0, 511)),
						kct_pkg::coord_t'($urandom_range(0, 511)));
			end
		end
		calm = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d beats with %0d countdowns run out to the alarm, %0d results checked",
			beats_sent, timer_sb.alarms_raised, timer_sb.beats_checked);
		$display("%0d display redraws and %0d menu releases seen, %0d mismatches",
			timer_sb.redraws, timer_sb.menu_exits, timer_sb.mismatches);
		if (timer_sb.mismatches == 0 && timer_sb.expected_views.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/kct_pkg.sv
rtl/kct_item_if.sv
rtl/kct_result_if.sv
rtl/kct_keymap.sv
rtl/keypad_countdown_timer_core.sv
rtl/kct_checker.sv
tb/sv/keypad_countdown_timer_core_test.sv
